// File: src/scytale_transposition_unit_assert.svh
// Assertion macros for the scytale transposition unit.
`ifndef SCYTALE_TRANSPOSITION_UNIT_ASSERT_SVH
`define SCYTALE_TRANSPOSITION_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SCYT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SCYT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/scyt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scyt_pkg;

    localparam int MAX_LEN  = 32;
    localparam int ADDR_W   = $clog2(MAX_LEN);
    localparam int LEN_W    = ADDR_W + 1;
    localparam int ROW_W    = 6;
    localparam int ACC_W    = ROW_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam logic [7:0]       SPACE_CHAR = 8'h20;
    localparam logic [ROW_W-1:0] ROWS_RESET = 6'd6;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 1'b1;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_in;
    } t_in;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_out;
        logic       overflow;
    } t_out;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_COLS,
        ST_READ,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic cols_init;
        logic cols_step;
        logic emit_init;
        logic rd;
        logic adv;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic cols_done;
        logic last_cell;
    } t_status;

endpackage

`default_nettype wire

// File: src/scyt_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module scyt_dp (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire scyt_pkg::t_cmd           i_cmd,
    input  wire scyt_pkg::t_in            i_in_data,
    input  wire logic [scyt_pkg::ROW_W-1:0] i_row_count,
    input  wire logic                     i_decrypt_mode,
    output scyt_pkg::t_status             o_status,
    output scyt_pkg::t_out                o_out_data
);
    import scyt_pkg::*;

    logic [7:0]       mem [MAX_LEN];
    logic [LEN_W-1:0] r_len;
    logic             r_drop;
    logic [ACC_W-1:0] r_acc;
    logic [ROW_W-1:0] r_cols;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] r_col;
    logic [ROW_W-1:0] r_idx;
    logic [7:0]       r_rd_char;
    logic             r_hit;
    logic             r_last;

    logic [ROW_W-1:0] rows_eff;
    logic             row_end;
    logic             col_end;

    assign rows_eff = (i_row_count == '0) ? ROW_W'(1) : i_row_count;
    assign row_end  = (r_row == rows_eff - ROW_W'(1));
    assign col_end  = (r_col == r_cols - ROW_W'(1));

    // The message buffer holds only what was written; unwritten entries are never hit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_len < LEN_W'(MAX_LEN))) begin
            mem[r_len[ADDR_W-1:0]] <= i_in_data.char_in;
        end
        if (i_cmd.rd) begin
            r_rd_char <= mem[r_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_drop <= 1'b0;
            r_cols <= ROW_W'(1);
        end else begin
            if (i_cmd.load) begin
                if (r_len < LEN_W'(MAX_LEN)) begin
                    r_len <= r_len + LEN_W'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.clear) begin
                r_len  <= '0;
                r_drop <= 1'b0;
            end
            // Column count by repeated addition of the row count.
            if (i_cmd.cols_init) begin
                r_cols <= ROW_W'(1);
            end else if (i_cmd.cols_step) begin
                r_cols <= r_cols + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cols_init) begin
            r_acc <= ACC_W'(rows_eff);
        end else if (i_cmd.cols_step) begin
            r_acc <= r_acc + ACC_W'(rows_eff);
        end

        if (i_cmd.emit_init) begin
            r_row <= '0;
            r_col <= '0;
            r_idx <= '0;
        end else if (i_cmd.adv) begin
            if (!i_decrypt_mode) begin
                // Row-major read of a column-filled grid.
                if (col_end) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_W'(1);
                    r_idx <= r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + ROW_W'(1);
                    r_idx <= r_idx + rows_eff;
                end
            end else begin
                // Column-major read of a row-filled grid.
                if (row_end) begin
                    r_row <= '0;
                    r_col <= r_col + ROW_W'(1);
                    r_idx <= r_col + ROW_W'(1);
                end else begin
                    r_row <= r_row + ROW_W'(1);
                    r_idx <= r_idx + r_cols;
                end
            end
        end

        if (i_cmd.rd) begin
            r_hit  <= ({1'b0, r_idx[ROW_W-2:0]} < r_len) && !r_idx[ROW_W-1];
            r_last <= row_end && col_end;
        end
    end

    assign o_status.cols_done = (r_acc >= ACC_W'(r_len));
    assign o_status.last_cell = r_last;

    assign o_out_data.char_out = r_hit ? r_rd_char : SPACE_CHAR;
    assign o_out_data.last_out = r_last;
    assign o_out_data.overflow = r_drop;

endmodule

`default_nettype wire

// File: src/scyt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module scyt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_last,
    input  wire logic              i_out_ready,
    input  wire scyt_pkg::t_status i_status,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output scyt_pkg::t_cmd         o_cmd
);
    import scyt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.cols_init = 1'b1;
                        n_state         = ST_COLS;
                    end
                end
            end
            ST_COLS: begin
                if (i_status.cols_done) begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = ST_READ;
                end else begin
                    o_cmd.cols_step = 1'b1;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.last_cell) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_LOAD;
                    end else begin
                        o_cmd.adv = 1'b1;
                        n_state   = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/scytale_transposition_unit.sv
// Scytale transposition unit. Message bytes stream in one per cycle while the unit
// is loading, up to 32 of them; bytes beyond that are dropped and every output of
// that message carries the overflow flag. The byte marked last closes the message:
// with R rows (zero counts as one) and L bytes the grid has ceil(L/R) columns, or
// one if L <= R, and exactly R times that many bytes come out, spaces filling the
// empty cells. Encrypt mode fills the grid by columns and reads it by rows; decrypt
// mode does the reverse. After the last byte the column count is found by
// repeated addition of R; each output byte is then read from the buffer and held
// in the output register until the consumer takes it, before the next is read.
// No input is taken while a message is being emitted. Configuration is written
// through its own port, always ready.
`timescale 1ns / 1ps
`default_nettype none

module scytale_transposition_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire scyt_pkg::t_in                  i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output scyt_pkg::t_out                      o_out_data,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [scyt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [scyt_pkg::ROW_W-1:0]     i_cfg_data
);
    import scyt_pkg::*;

    logic [ROW_W-1:0] r_row_count;
    logic             r_decrypt_mode;
    t_cmd             cmd;
    t_status          status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= ROWS_RESET;
            r_decrypt_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ROW_COUNT:    r_row_count    <= i_cfg_data;
                REG_DECRYPT_MODE: r_decrypt_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    scyt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.last_in),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    scyt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_in_data      (i_in_data),
        .i_row_count    (r_row_count),
        .i_decrypt_mode (r_decrypt_mode),
        .o_status       (status),
        .o_out_data     (o_out_data)
    );

`include "scytale_transposition_unit_assert.svh"

    `SCYT_ASSERT_NOW(a_no_input_while_emitting, o_out_valid, !o_in_ready,
        "input ready while a result is pending")
    `SCYT_ASSERT_NEXT(a_last_in_closes_load, i_in_valid && o_in_ready && i_in_data.last_in,
        !o_in_ready, "input still taken after the last byte of a message")
    `SCYT_ASSERT_NEXT(a_last_out_reopens_load,
        o_out_valid && i_out_ready && o_out_data.last_out, o_in_ready && !o_out_valid,
        "unit did not return to loading after the final output byte")

endmodule

`default_nettype wire
